// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHECK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/uhrm_pkg.sv -----
package uhrm_pkg;

   localparam int TAG_W    = 3;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;

   typedef logic [TAG_W-1:0] tag_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 2'd0,
      OP_UNDO = 2'd1,
      OP_REDO = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED        = 3'd0,
      ST_ADDED_EVICT  = 3'd1,
      ST_UNDO_SLOT    = 3'd2,
      ST_UNDO_BASE    = 3'd3,
      ST_UNDO_REFUSED = 3'd4,
      ST_REDO         = 3'd5,
      ST_REDO_REFUSED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVICT,
      S_UNDO_TAG,
      S_UNDO_SEARCH,
      S_REDO
   } state_type;

endpackage

// ----- hw/rtl/uhrm_ram.sv -----
module uhrm_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 20,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/undo_history_ring_manager_core.sv -----
// Undo/redo history ring manager. A request is taken when start is high and busy is low;
// each request (except the unused operation code, which is dropped) yields one response,
// shown for exactly one cycle with rsp_strobe high; the receiver cannot stall it. Add and
// redo are answered from S_IDLE, S_EVICT or S_REDO; an undo is answered from S_IDLE,
// S_UNDO_TAG or S_UNDO_SEARCH: the undo search reads one slot tag per cycle from the tag
// memory. busy is high while a request is in progress; tags read as zero until first written.
`include "assert_macros.svh"

module undo_history_ring_manager_core #(
   parameter int RING_DEPTH  = 20,
   parameter int LAYER_COUNT = 8,
   localparam int SLOT_W = $clog2(RING_DEPTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [uhrm_pkg::OP_W-1:0]      req_operation,
   input  logic [uhrm_pkg::TAG_W-1:0]     req_layer_index,
   output logic                           rsp_strobe,
   output logic [uhrm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [uhrm_pkg::TAG_W-1:0]     rsp_target_layer,
   output logic [SLOT_W-1:0]              rsp_source_slot,
   output logic [SLOT_W-1:0]              rsp_evict_slot,
   output logic [uhrm_pkg::TAG_W-1:0]     rsp_evict_layer
);

   import uhrm_pkg::*;

   localparam int LAYER_VALUES = 2 ** TAG_W;

   function automatic logic [SLOT_W-1:0] ring_inc(input logic [SLOT_W-1:0] p);
      ring_inc = (p == SLOT_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] ring_dec(input logic [SLOT_W-1:0] p);
      ring_dec = (p == '0) ? SLOT_W'(RING_DEPTH - 1) : p - 1'b1;
   endfunction

   state_type              state_ff, state_in;
   logic [SLOT_W-1:0]      next_ff, next_in;
   logic [SLOT_W-1:0]      oldest_ff, oldest_in;
   logic [SLOT_W-1:0]      cur_ff, cur_in;
   tag_type                layer_ff, layer_in;
   tag_type                tag_ff, tag_in;
   logic [RING_DEPTH-1:0]  valid_ff, valid_in;
   logic                   rd_valid_ff, rd_valid_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   status_type             rsp_status_ff, rsp_status_in;
   tag_type                rsp_target_ff, rsp_target_in;
   logic [SLOT_W-1:0]      rsp_source_ff, rsp_source_in;
   logic [SLOT_W-1:0]      rsp_evict_slot_ff, rsp_evict_slot_in;
   tag_type                rsp_evict_layer_ff, rsp_evict_layer_in;

   logic                   wr_en;
   logic [SLOT_W-1:0]      wr_addr;
   tag_type                wr_data;
   logic [SLOT_W-1:0]      rd_addr;
   tag_type                rd_data;
   tag_type                rd_tag;

   tag_type                layer_tbl [LAYER_VALUES];
   tag_type                layer_mod;
   logic [SLOT_W-1:0]      next_inc;
   logic [SLOT_W-1:0]      next_dec;
   logic [SLOT_W-1:0]      cur_dec;

   for (genvar v = 0; v < LAYER_VALUES; v++) begin : g_layer_tbl
      assign layer_tbl[v] = TAG_W'(v % LAYER_COUNT);
   end

   assign layer_mod   = layer_tbl[req_layer_index];
   assign next_inc    = ring_inc(next_ff);
   assign next_dec    = ring_dec(next_ff);
   assign cur_dec     = ring_dec(cur_ff);
   assign rd_tag      = rd_valid_ff ? rd_data : '0;
   assign rd_valid_in = valid_ff[rd_addr];
   assign busy        = (state_ff != S_IDLE);

   uhrm_ram #(
      .WIDTH (TAG_W),
      .DEPTH (RING_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_ff       <= '0;
         oldest_ff     <= '0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_ff       <= next_in;
         oldest_ff     <= oldest_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff             <= cur_in;
      layer_ff           <= layer_in;
      tag_ff             <= tag_in;
      rd_valid_ff        <= rd_valid_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_target_ff      <= rsp_target_in;
      rsp_source_ff      <= rsp_source_in;
      rsp_evict_slot_ff  <= rsp_evict_slot_in;
      rsp_evict_layer_ff <= rsp_evict_layer_in;
   end

   always_comb begin
      state_in           = state_ff;
      next_in            = next_ff;
      oldest_in          = oldest_ff;
      cur_in             = cur_ff;
      layer_in           = layer_ff;
      tag_in             = tag_ff;
      valid_in           = valid_ff;
      wr_en              = 1'b0;
      wr_addr            = next_ff;
      wr_data            = layer_mod;
      rd_addr            = cur_ff;
      rsp_strobe_in      = 1'b0;
      rsp_status_in      = ST_ADDED;
      rsp_target_in      = '0;
      rsp_source_in      = '0;
      rsp_evict_slot_in  = '0;
      rsp_evict_layer_in = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (op_type'(req_operation))
                  OP_ADD: begin
                     wr_en             = 1'b1;
                     valid_in[next_ff] = 1'b1;
                     layer_in          = layer_mod;
                     cur_in            = next_ff;
                     next_in           = next_inc;
                     if (next_inc == oldest_ff) begin
                        oldest_in = ring_inc(oldest_ff);
                        rd_addr   = next_inc;
                        state_in  = S_EVICT;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_ADDED;
                        rsp_target_in = layer_mod;
                        rsp_source_in = next_ff;
                     end
                  end
                  OP_UNDO: begin
                     if (next_ff == oldest_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_UNDO_REFUSED;
                     end else begin
                        next_in  = next_dec;
                        rd_addr  = next_dec;
                        state_in = S_UNDO_TAG;
                     end
                  end
                  OP_REDO: begin
                     if (next_inc == oldest_ff) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_REDO_REFUSED;
                     end else begin
                        rd_addr  = next_ff;
                        cur_in   = next_ff;
                        next_in  = next_inc;
                        state_in = S_REDO;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EVICT: begin
            rsp_strobe_in      = 1'b1;
            rsp_status_in      = ST_ADDED_EVICT;
            rsp_target_in      = layer_ff;
            rsp_source_in      = cur_ff;
            rsp_evict_slot_in  = next_ff;
            rsp_evict_layer_in = rd_tag;
            state_in           = S_IDLE;
         end
         S_UNDO_TAG: begin
            tag_in = rd_tag;
            if (next_ff == oldest_ff || next_dec == oldest_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_UNDO_BASE;
               rsp_target_in = rd_tag;
               state_in      = S_IDLE;
            end else begin
               rd_addr  = next_dec;
               cur_in   = next_dec;
               state_in = S_UNDO_SEARCH;
            end
         end
         S_UNDO_SEARCH: begin
            if (rd_tag == tag_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_UNDO_SLOT;
               rsp_target_in = tag_ff;
               rsp_source_in = cur_ff;
               state_in      = S_IDLE;
            end else if (cur_dec == oldest_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_UNDO_BASE;
               rsp_target_in = tag_ff;
               state_in      = S_IDLE;
            end else begin
               rd_addr = cur_dec;
               cur_in  = cur_dec;
            end
         end
         S_REDO: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_REDO;
            rsp_target_in = rd_tag;
            rsp_source_in = cur_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_target_layer = rsp_target_ff;
   assign rsp_source_slot  = rsp_source_ff;
   assign rsp_evict_slot   = rsp_evict_slot_ff;
   assign rsp_evict_layer  = rsp_evict_layer_ff;

   `CHECK_IMPLY(a_evict_fields_zero, clock, reset,
      rsp_strobe_ff && rsp_status_ff != ST_ADDED_EVICT,
      rsp_evict_slot_ff == '0 && rsp_evict_layer_ff == '0,
      "evict fields set without eviction")
   `CHECK_NEXT(a_request_progress, clock, reset,
      start && !busy && (req_operation == OP_ADD || req_operation == OP_UNDO ||
                         req_operation == OP_REDO),
      busy || rsp_strobe, "request neither in progress nor answered")
   `CHECK_IMPLY(a_search_not_oldest, clock, reset, state_ff == S_UNDO_SEARCH,
      cur_ff != oldest_ff, "undo search reached oldest slot")
   `CHECK_IMPLY(a_pointers_in_ring, clock, reset, 1'b1,
      next_ff <= SLOT_W'(RING_DEPTH - 1) && oldest_ff <= SLOT_W'(RING_DEPTH - 1),
      "ring pointer out of range")

endmodule

// ----- tb/tb_undo_history_ring_manager_core.sv -----
`timescale 1ns / 1ps

module tb_undo_history_ring_manager_core;
   import uhrm_pkg::*;

   localparam int DEPTH        = 20;
   localparam int LAYERS       = 8;
   localparam int SLOT_W       = $clog2(DEPTH);
   localparam int ITEMS        = 1550;
   localparam int CALM_TAIL    = 200;
   localparam int STALL_LIMIT  = 1000;
   localparam int MAX_SHOWN    = 10;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 4;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int SCRIPT_ROWS  = 12;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      tag_type             target;
      logic [SLOT_W-1:0]   source;
      logic [SLOT_W-1:0]   evict_slot;
      tag_type             evict_layer;
   } outcome_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      tag_type         layer;
      int unsigned     count;
      bit              typed;
      outcome_type     outcome;
   } script_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_operation = OP_ADD;
   tag_type             req_layer_index = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   tag_type             rsp_target_layer;
   logic [SLOT_W-1:0]   rsp_source_slot;
   logic [SLOT_W-1:0]   rsp_evict_slot;
   tag_type             rsp_evict_layer;

   // typed-in expectation that travels with the request currently driven
   bit                  typed_flag = 1'b0;
   outcome_type         typed_outcome = '0;

   tag_type             log_tags [DEPTH];
   logic [SLOT_W-1:0]   log_oldest;
   logic [SLOT_W-1:0]   log_next;

   outcome_type         awaited_outcomes [$];
   outcome_type         forecast;
   outcome_type         want;
   int unsigned         fault_count = 0;
   int unsigned         stall_cycles = 0;
   bit                  active;

   script_row_type script [SCRIPT_ROWS] = '{
      '{OP_UNDO,   3'd0, 1,  1'b1, '{ST_UNDO_REFUSED, 3'd0, 5'd0, 5'd0, 3'd0}},
      '{OP_REDO,   3'd0, 1,  1'b1, '{ST_REDO,         3'd0, 5'd0, 5'd0, 3'd0}},
      '{OP_UNUSED, 3'd5, 1,  1'b0, '0},
      '{OP_UNDO,   3'd0, 1,  1'b0, '0},
      '{OP_ADD,    3'd7, 1,  1'b0, '0},
      '{OP_ADD,    3'd0, 1,  1'b0, '0},
      '{OP_ADD,    3'd7, 2,  1'b0, '0},
      '{OP_UNDO,   3'd0, 1,  1'b0, '0},
      '{OP_REDO,   3'd0, 1,  1'b0, '0},
      '{OP_ADD,    3'd5, 17, 1'b0, '0},
      '{OP_REDO,   3'd0, 1,  1'b1, '{ST_REDO_REFUSED, 3'd0, 5'd0, 5'd0, 3'd0}},
      '{OP_UNDO,   3'd2, 2,  1'b0, '0}
   };

   undo_history_ring_manager_core #(
      .RING_DEPTH  (DEPTH),
      .LAYER_COUNT (LAYERS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_layer_index  (req_layer_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_target_layer (rsp_target_layer),
      .rsp_source_slot  (rsp_source_slot),
      .rsp_evict_slot   (rsp_evict_slot),
      .rsp_evict_layer  (rsp_evict_layer)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [SLOT_W-1:0] ring_up(input logic [SLOT_W-1:0] p);
      return (p == DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] ring_down(input logic [SLOT_W-1:0] p);
      return (p == 0) ? SLOT_W'(DEPTH - 1) : p - 1'b1;
   endfunction

   // updates the history copy; returns 0 when the request yields no response
   function automatic bit forecast_restore(input logic [OP_W-1:0] op, input tag_type layer,
                                           output outcome_type res);
      logic [SLOT_W-1:0] written;
      logic [SLOT_W-1:0] probe;
      tag_type           tag;
      tag_type           kept;
      res = '0;
      kept = tag_type'(layer % LAYERS);
      case (op)
         OP_ADD: begin
            written = log_next;
            log_tags[written] = kept;
            log_next = ring_up(log_next);
            res.target = kept;
            res.source = written;
            if (log_next == log_oldest) begin
               log_oldest = ring_up(log_oldest);
               res.status = ST_ADDED_EVICT;
               res.evict_slot = log_next;
               res.evict_layer = log_tags[log_next];
            end else begin
               res.status = ST_ADDED;
            end
         end
         OP_UNDO: begin
            if (log_next == log_oldest) begin
               res.status = ST_UNDO_REFUSED;
            end else begin
               log_next = ring_down(log_next);
               tag = log_tags[log_next];
               probe = ring_down(log_next);
               for (int n = 0; n < DEPTH; n++) begin
                  if (probe == log_oldest || log_tags[probe] == tag) break;
                  probe = ring_down(probe);
               end
               res.target = tag;
               if (probe == log_oldest || log_next == log_oldest) begin
                  res.status = ST_UNDO_BASE;
               end else begin
                  res.status = ST_UNDO_SLOT;
                  res.source = probe;
               end
            end
         end
         OP_REDO: begin
            if (ring_up(log_next) == log_oldest) begin
               res.status = ST_REDO_REFUSED;
            end else begin
               res.status = ST_REDO;
               res.target = log_tags[log_next];
               res.source = log_next;
               log_next = ring_up(log_next);
            end
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   initial begin
      for (int i = 0; i < DEPTH; i++) log_tags[i] = '0;
      log_oldest = '0;
      log_next = '0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         active = 1'b0;
         if (start && !busy) begin
            active = 1'b1;
            if (forecast_restore(req_operation, req_layer_index, forecast))
               awaited_outcomes.push_back(typed_flag ? typed_outcome : forecast);
         end
         if (rsp_strobe) begin
            active = 1'b1;
            if (awaited_outcomes.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_SHOWN)
                  $display("%0t: response with none pending: status %0d", $time, rsp_status);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_status !== want.status || rsp_target_layer !== want.target ||
                   rsp_source_slot !== want.source || rsp_evict_slot !== want.evict_slot ||
                   rsp_evict_layer !== want.evict_layer) begin
                  fault_count++;
                  if (fault_count <= MAX_SHOWN) begin
                     $display("%0t: mismatch exp st=%0d tl=%0d src=%0d es=%0d el=%0d",
                              $time, want.status, want.target, want.source,
                              want.evict_slot, want.evict_layer);
                     $display("%0t: mismatch got st=%0d tl=%0d src=%0d es=%0d el=%0d",
                              $time, rsp_status, rsp_target_layer, rsp_source_slot,
                              rsp_evict_slot, rsp_evict_layer);
                  end
               end
            end
         end
         stall_cycles = active ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_undo_history_ring_manager_core: FAIL");
            $finish;
         end
      end
   end

   task automatic issue(input logic [OP_W-1:0] op, input tag_type layer, input bit typed,
                        input outcome_type outcome);
      start <= 1'b1;
      req_operation <= op;
      req_layer_index <= layer;
      typed_flag <= typed;
      typed_outcome <= outcome;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   initial begin
      int unsigned     sent;
      int unsigned     kind;
      int unsigned     len;
      int unsigned     span;
      int unsigned     pick;
      tag_type         offset;
      tag_type         layer;
      logic [OP_W-1:0] op;
      bit              idle_on;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[r]) begin
         for (int k = 0; k < script[r].count; k++)
            issue(script[r].op, script[r].layer, script[r].typed, script[r].outcome);
      end

      sent = 0;
      while (sent < ITEMS) begin
         kind = $urandom_range(0, 9);
         span = $urandom_range(0, 7);
         offset = tag_type'($urandom_range(0, 7));
         idle_on = (sent + CALM_TAIL < ITEMS) && ($urandom_range(0, 3) != 0);
         case (kind)
            0, 1, 2: len = $urandom_range(1, 24);
            3, 4, 5: len = $urandom_range(1, 22);
            default: len = $urandom_range(1, 12);
         endcase
         for (int k = 0; k < len; k++) begin
            layer = tag_type'($urandom_range(0, span)) ^ offset;
            case (kind)
               0, 1, 2: op = OP_ADD;
               3, 4:    op = OP_UNDO;
               5:       op = OP_REDO;
               default: begin
                  pick = $urandom_range(0, 15);
                  if (pick < 7)       op = OP_ADD;
                  else if (pick < 12) op = OP_UNDO;
                  else if (pick < 15) op = OP_REDO;
                  else                op = OP_UNUSED;
               end
            endcase
            if (idle_on && $urandom_range(0, 3) == 0)
               hold_off($urandom_range(1, 15));
            issue(op, layer, 1'b0, '0);
            if (op != OP_UNUSED) sent++;
         end
      end
      start <= 1'b0;

      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && awaited_outcomes.size() == 0) begin
         $display("tb_undo_history_ring_manager_core: PASS");
      end else begin
         $display("tb_undo_history_ring_manager_core: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/uhrm_pkg.sv
hw/rtl/uhrm_ram.sv
hw/rtl/undo_history_ring_manager_core.sv
tb/tb_undo_history_ring_manager_core.sv
